// ----- hw/rtl/kscl_pkg.sv -----
// Shared types, key codes and register map for the keypad scanner code lock.
`timescale 1ns / 1ps
`default_nettype none
package kscl_pkg;

    localparam int MAX_DIGITS_DEF = 11;

    localparam int PERIOD_W = 10;
    localparam int CODE_W   = 37;
    localparam int COLS_W   = 4;
    localparam int ROWS_W   = 4;
    localparam int ROW_IDX_W = 2;
    localparam int KEYS_W   = 16;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 64;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd20;
    localparam logic [CODE_W-1:0]   CODE_RST   = 37'd62340500022;

    // Register index, taken from the 8-byte slot of paddr.
    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_CODE   = 1'b1;

    typedef logic [KEYS_W-1:0] t_keys;

    localparam t_keys KEY_CLEAR = 16'h0008;
    localparam t_keys KEY_BACK  = 16'h0080;
    localparam t_keys KEY_OK    = 16'h8000;

    typedef struct packed {
        logic       is_digit;
        logic [3:0] digit;
    } t_digit;

    // 10**digits, evaluated at elaboration only.
    function automatic longint unsigned pow10(input int digits);
        longint unsigned p;
        p = 1;
        for (int n = 0; n < digits; n++) begin
            p = p * 10;
        end
        return p;
    endfunction

    function automatic t_digit digit_of(input t_keys code);
        t_digit d;
        d.is_digit = 1'b1;
        d.digit    = 4'd0;
        unique case (code)
            16'h0001: d.digit = 4'd7;
            16'h0002: d.digit = 4'd8;
            16'h0004: d.digit = 4'd9;
            16'h0010: d.digit = 4'd4;
            16'h0020: d.digit = 4'd5;
            16'h0040: d.digit = 4'd6;
            16'h0100: d.digit = 4'd1;
            16'h0200: d.digit = 4'd2;
            16'h0400: d.digit = 4'd3;
            16'h1000: d.digit = 4'd0;
            default:  d.is_digit = 1'b0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/keypad_scan_code_lock.sv -----
// Top level: 4x4 keypad row scanner with decimal code entry and lock lamp.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------
//  in        | i_in_valid / o_in_ready   | i_column_levels
//  out       | o_out_valid / i_out_ready | o_row_lines, o_lock_lamp,
//            |                           | o_entered_number, o_pressed_keys
//  config    | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied high)
//
// One request per cycle sustained while the output is not stalled; a request passes the input
// register, then the scan/decode logic writes the state registers, which double as the result register.
// The scan counter, row, key map and digit stack advance only when a result is loaded.
// A stalled output holds the result and the input register; o_in_ready drops only when
// both are full. Synchronous active-low reset, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module keypad_scan_code_lock #(
    parameter int MAX_DIGITS = kscl_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [kscl_pkg::COLS_W-1:0]   i_column_levels,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [kscl_pkg::ROWS_W-1:0]        o_row_lines,
    output logic                               o_lock_lamp,
    output logic [kscl_pkg::CODE_W-1:0]        o_entered_number,
    output logic [kscl_pkg::KEYS_W-1:0]        o_pressed_keys,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [kscl_pkg::APB_AW-1:0]   paddr,
    input  wire logic [kscl_pkg::APB_DW-1:0]   pwdata,
    output logic [kscl_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import kscl_pkg::*;

    localparam longint unsigned POW   = pow10(MAX_DIGITS);
    localparam int              VAL_W = $clog2(POW);
    localparam int              CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int              IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int              CMP_W = (VAL_W > CODE_W) ? VAL_W : CODE_W;
    localparam logic [VAL_W-1:0]  VAL_MAX = VAL_W'(POW - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_DIGITS);

    // Configuration
    logic [PERIOD_W-1:0] r_scan_period;
    logic [CODE_W-1:0]   r_secret_code;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_period <= PERIOD_RST;
            r_secret_code <= CODE_RST;
        end else if (cfg_wr) begin
            if (paddr[3] == REG_PERIOD) begin
                r_scan_period <= pwdata[PERIOD_W-1:0];
            end else begin
                r_secret_code <= pwdata[CODE_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[3] == REG_CODE) begin
            prdata = {{(APB_DW-CODE_W){1'b0}}, r_secret_code};
        end else begin
            prdata = {{(APB_DW-PERIOD_W){1'b0}}, r_scan_period};
        end
    end

    // Input register
    logic              r_in_valid;
    logic [COLS_W-1:0] r_in_cols;
    logic              advance;

    assign advance    = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_cols <= i_column_levels;
        end
    end

    // State, which is also the result
    logic                 r_out_valid;
    logic [PERIOD_W-1:0]  r_elapsed;
    logic [ROW_IDX_W-1:0] r_row;
    logic [ROWS_W-1:0]    r_row_drive;
    t_keys                r_key_map;
    logic                 r_was_down;
    logic [VAL_W-1:0]     r_value;
    logic                 r_lamp;
    logic [CNT_W-1:0]     r_digit_cnt;
    logic [VAL_W-1:0]     r_prefix [MAX_DIGITS];

    logic [PERIOD_W-1:0]  n_elapsed;
    logic [ROW_IDX_W-1:0] n_row;
    logic [ROWS_W-1:0]    n_row_drive;
    t_keys                n_key_map;
    logic                 n_was_down;
    logic [VAL_W-1:0]     n_value;
    logic                 n_lamp;
    logic [CNT_W-1:0]     n_digit_cnt;
    logic                 push;

    logic [PERIOD_W:0]    tick_sum;
    logic                 scan;
    t_digit               dig;
    logic [VAL_W+3:0]     times_ten;
    logic [CNT_W-1:0]     cnt_dec;
    logic [IDX_W-1:0]     push_idx;
    logic [IDX_W-1:0]     pop_idx;
    logic [CMP_W-1:0]     val_ext;
    logic [CMP_W-1:0]     code_ext;
    logic [VAL_W+CODE_W-1:0] val_out;

    assign tick_sum  = {1'b0, r_elapsed} + (PERIOD_W+1)'(1);
    assign scan      = tick_sum >= {1'b0, r_scan_period};
    assign times_ten = {1'b0, r_value, 3'b000} + {3'b000, r_value, 1'b0}
                     + (VAL_W+4)'(dig.digit);
    assign cnt_dec   = r_digit_cnt - CNT_W'(1);
    assign push_idx  = r_digit_cnt[IDX_W-1:0];
    assign pop_idx   = cnt_dec[IDX_W-1:0];
    assign val_ext   = CMP_W'(r_value);
    assign code_ext  = CMP_W'(r_secret_code);
    assign dig       = digit_of(n_key_map);

    always_comb begin
        n_elapsed   = tick_sum[PERIOD_W-1:0];
        n_row       = r_row;
        n_row_drive = r_row_drive;
        n_key_map   = r_key_map;
        if (scan) begin
            n_key_map[{r_row, 2'b00} +: COLS_W] = ~r_in_cols;
            n_row       = r_row + ROW_IDX_W'(1);
            n_row_drive = ~(ROWS_W'(1) << n_row);
            n_elapsed   = '0;
        end
    end

    always_comb begin
        n_was_down  = n_key_map != '0;
        n_value     = r_value;
        n_lamp      = r_lamp;
        n_digit_cnt = r_digit_cnt;
        push        = 1'b0;
        // Act only on a fresh press: key map leaves zero.
        if (n_was_down && !r_was_down) begin
            if (dig.is_digit) begin
                // Leading zeros leave the value and the digit count alone.
                if (r_digit_cnt < CNT_MAX && times_ten != '0) begin
                    n_value     = times_ten[VAL_W-1:0];
                    n_digit_cnt = r_digit_cnt + CNT_W'(1);
                    push        = 1'b1;
                end
            end else if (n_key_map == KEY_CLEAR) begin
                n_value     = '0;
                n_digit_cnt = '0;
                n_lamp      = 1'b0;
            end else if (n_key_map == KEY_BACK) begin
                // Drop the last digit by restoring the shorter prefix.
                if (r_digit_cnt != '0) begin
                    n_value     = r_prefix[pop_idx];
                    n_digit_cnt = cnt_dec;
                end
            end else if (n_key_map == KEY_OK) begin
                n_lamp = val_ext == code_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_elapsed   <= '0;
            r_row       <= '0;
            r_row_drive <= '1;
            r_key_map   <= '0;
            r_was_down  <= 1'b0;
            r_value     <= '0;
            r_lamp      <= 1'b0;
            r_digit_cnt <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_elapsed   <= n_elapsed;
                r_row       <= n_row;
                r_row_drive <= n_row_drive;
                r_key_map   <= n_key_map;
                r_was_down  <= n_was_down;
                r_value     <= n_value;
                r_lamp      <= n_lamp;
                r_digit_cnt <= n_digit_cnt;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Prefix stack: entry k holds the value as it stood with k digits.
    always_ff @(posedge i_clk) begin
        if (advance && push) begin
            r_prefix[push_idx] <= r_value;
        end
    end

    assign val_out          = {{CODE_W{1'b0}}, r_value};
    assign o_out_valid      = r_out_valid;
    assign o_row_lines      = r_row_drive;
    assign o_lock_lamp      = r_lamp;
    assign o_entered_number = val_out[CODE_W-1:0];
    assign o_pressed_keys   = r_key_map;

    // Checks
    a_zero_cnt_zero_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit_cnt == '0 |-> r_value == '0)
        else $error("digit count zero with nonzero value");

    a_value_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_value <= VAL_MAX && r_digit_cnt <= CNT_MAX)
        else $error("entered value beyond digit limit");

    a_one_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(~r_row_drive) <= 1)
        else $error("more than one row driven");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("input stalled while pipeline has room");

    a_lamp_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_lamp) |-> r_key_map == KEY_OK && !$past(r_was_down))
        else $error("lamp set without a fresh OK press");

endmodule
`default_nettype wire

// ----- verif/keypad_scan_code_lock_tb.sv -----
// Self-checking testbench for the keypad scanner code lock: directed table, then keypad sessions.
`timescale 1ns / 1ps
module keypad_scan_code_lock_tb;
    import kscl_pkg::*;

    typedef struct packed {
        logic [ROWS_W-1:0] row_lines;
        logic              lamp;
        logic [CODE_W-1:0] number;
        t_keys             keys;
    } t_panel;

    typedef struct packed {
        logic [COLS_W-1:0] cols;
        logic              fixed;
        t_panel            want;
    } t_step;

    localparam longint unsigned DIGIT_CAP = 64'd99999999999;
    localparam longint unsigned CODE_ALL  = (64'd1 << CODE_W) - 1;

    // key code for each decimal digit, indexed by the digit
    localparam t_keys DIGIT_KEY [10] = '{
        16'h1000, 16'h0100, 16'h0200, 16'h0400, 16'h0010,
        16'h0020, 16'h0040, 16'h0001, 16'h0002, 16'h0004
    };

    localparam t_panel BLANK   = '0;
    localparam t_panel AT_REST = {4'hF, 1'b0, 37'd0, 16'h0000};

    localparam int DIRECTED_LEN = 33;
    localparam int SETUP_ROW    = 2;

    // Rows before SETUP_ROW run at reset settings; from there on one row is scanned
    // per request (row 0, 1, 2, 3, ...), with the code set to 1.
    localparam t_step DIRECTED_STEPS [DIRECTED_LEN] = '{
        {4'hF, 1'b1, AT_REST}, {4'h0, 1'b1, AT_REST},
        {4'hF, 1'b1, {4'hD, 1'b0, 37'd0, 16'h0000}},
        {4'h0, 1'b1, {4'hB, 1'b0, 37'd0, 16'h00F0}},
        {4'hF, 1'b0, BLANK}, {4'hF, 1'b0, BLANK}, {4'hF, 1'b0, BLANK},
        {4'hF, 1'b1, {4'hB, 1'b0, 37'd0, 16'h0000}},
        {4'hE, 1'b0, BLANK}, {4'hF, 1'b0, BLANK}, {4'hF, 1'b0, BLANK},
        {4'hF, 1'b0, BLANK}, {4'hF, 1'b0, BLANK},
        {4'h7, 1'b0, BLANK}, {4'hF, 1'b0, BLANK}, {4'hF, 1'b0, BLANK},
        {4'hF, 1'b0, BLANK}, {4'hF, 1'b0, BLANK},
        {4'h7, 1'b0, BLANK}, {4'hF, 1'b0, BLANK}, {4'hF, 1'b0, BLANK},
        {4'hF, 1'b0, BLANK}, {4'hF, 1'b0, BLANK},
        {4'h7, 1'b0, BLANK}, {4'hF, 1'b0, BLANK}, {4'hF, 1'b0, BLANK},
        {4'hF, 1'b0, BLANK}, {4'hF, 1'b0, BLANK},
        {4'h7, 1'b0, BLANK}, {4'hF, 1'b0, BLANK}, {4'hF, 1'b0, BLANK},
        {4'hF, 1'b0, BLANK}, {4'hF, 1'b0, BLANK}
    };

    localparam int PHASE_PERIOD [6] = '{1, 2, 0, 3, 1023, 1};
    localparam int PHASE_ITEMS  [6] = '{180, 80, 70, 60, 300, 120};

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_in_valid      = 1'b0;
    logic [COLS_W-1:0]   i_column_levels = 4'hF;
    logic                i_out_ready     = 1'b0;
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [APB_AW-1:0]   paddr           = '0;
    logic [APB_DW-1:0]   pwdata          = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [ROWS_W-1:0]   o_row_lines;
    logic                o_lock_lamp;
    logic [CODE_W-1:0]   o_entered_number;
    t_keys               o_pressed_keys;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    keypad_scan_code_lock u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_column_levels  (i_column_levels),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_row_lines      (o_row_lines),
        .o_lock_lamp      (o_lock_lamp),
        .o_entered_number (o_entered_number),
        .o_pressed_keys   (o_pressed_keys),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial forever #2 i_clk = ~i_clk;

    initial begin
        #1_000_000;
        $display("keypad_scan_code_lock_tb: done, errors");
        $finish;
    end

    // predicted block state and register copies
    logic [PERIOD_W-1:0] scan_period_r = PERIOD_RST;
    logic [CODE_W-1:0]   code_r        = CODE_RST;
    logic [PERIOD_W-1:0] tick_count    = '0;
    logic [1:0]          row_sel       = '0;
    logic [ROWS_W-1:0]   row_drive     = 4'hF;
    t_keys               key_map       = '0;
    logic                key_down      = 1'b0;
    longint unsigned     entry         = 0;
    logic                lamp_on       = 1'b0;

    t_panel panel_expected [$];
    t_keys  held_keys  = '0;
    bit     calm       = 1'b0;
    int     items_sent = 0;
    int     mismatches = 0;

    function automatic t_panel scan_and_decode(input logic [COLS_W-1:0] cols);
        int unsigned next_count;
        int          dig;
        next_count = tick_count + 1;
        if (next_count >= scan_period_r) begin
            key_map[row_sel*4 +: 4] = ~cols;
            row_sel   = row_sel + 2'd1;
            row_drive = ~(4'b0001 << row_sel);
            tick_count = '0;
        end else begin
            tick_count = next_count[PERIOD_W-1:0];
        end
        // act on a fresh press only
        if (key_map != '0 && !key_down) begin
            dig = -1;
            for (int d = 0; d < 10; d++) begin
                if (key_map == DIGIT_KEY[d]) dig = d;
            end
            if (dig >= 0) begin
                if (entry <= DIGIT_CAP / 10 && entry * 10 + longint'(dig) <= DIGIT_CAP) begin
                    entry = entry * 10 + longint'(dig);
                end
            end else if (key_map == KEY_CLEAR) begin
                entry   = 0;
                lamp_on = 1'b0;
            end else if (key_map == KEY_BACK) begin
                entry = entry / 10;
            end else if (key_map == KEY_OK) begin
                lamp_on = (entry == code_r);
            end
        end
        key_down = (key_map != '0);
        return {row_drive, lamp_on, entry[CODE_W-1:0], key_map};
    endfunction

    function automatic longint unsigned random_code();
        return {$urandom, $urandom} % (DIGIT_CAP + 1);
    endfunction

    // Column levels a keypad with held_keys pressed shows on the next request;
    // only scan ticks are sampled, so the others carry noise.
    function automatic logic [COLS_W-1:0] column_levels_now();
        if (tick_count + 1 >= scan_period_r) return ~held_keys[row_sel*4 +: 4];
        return COLS_W'($urandom_range(15));
    endfunction

    task automatic push_columns(input logic [COLS_W-1:0] cols, input logic fixed,
                                input t_panel want);
        t_panel got;
        if (!calm && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 36);
        end
        i_in_valid      <= 1'b1;
        i_column_levels <= cols;
        do @(posedge i_clk); while (!o_in_ready);
        got = scan_and_decode(cols);
        panel_expected.push_back(fixed ? want : got);
        items_sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [APB_DW-1:0] wdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_PERIOD) scan_period_r = wdata[PERIOD_W-1:0];
        else code_r = wdata[CODE_W-1:0];
    endtask

    // Hold off until every result is back, then program both registers
    // with junk in the unused upper bits.
    task automatic configure(input logic [PERIOD_W-1:0] period, input logic [CODE_W-1:0] code);
        logic [APB_DW-1:0] wdata;
        i_in_valid <= 1'b0;
        while (panel_expected.size() != 0) @(posedge i_clk);
        wdata = {$urandom, $urandom};
        wdata[PERIOD_W-1:0] = period;
        write_reg(REG_PERIOD, wdata);
        wdata = {$urandom, $urandom};
        wdata[CODE_W-1:0] = code;
        write_reg(REG_CODE, wdata);
    endtask

    // Release everything, press mask until the scanner has seen all of it, release.
    task automatic tap(input t_keys mask);
        held_keys = '0;
        while (key_map != '0) push_columns(column_levels_now(), 1'b0, BLANK);
        held_keys = mask;
        while ((key_map & mask) != mask) push_columns(column_levels_now(), 1'b0, BLANK);
        held_keys = '0;
    endtask

    task automatic keypad_action();
        int              pick;
        int              count;
        int              digits [$];
        longint unsigned target;
        t_keys           mask;
        pick = $urandom_range(99);
        if (pick < 35) begin
            // code entry: clear, digits, OK; mostly the right code
            if ($urandom_range(99) < 60) target = code_r;
            else if ($urandom_range(1)) target = code_r / 10;
            else target = random_code();
            do begin
                digits.push_front(int'(target % 10));
                target = target / 10;
            end while (target != 0);
            tap(KEY_CLEAR);
            foreach (digits[k]) tap(DIGIT_KEY[digits[k]]);
            tap(KEY_OK);
        end else if (pick < 45) begin
            // run past the digit cap
            count = $urandom_range(12, 14);
            tap(KEY_CLEAR);
            repeat (count) tap(DIGIT_KEY[($urandom_range(99) < 70) ? 9 : $urandom_range(9)]);
            tap(KEY_OK);
        end else if (pick < 75) begin
            tap(t_keys'(1) << $urandom_range(15));
        end else if (pick < 85) begin
            mask = t_keys'($urandom_range(16'hFFFF));
            if (mask == '0) mask = '1;
            tap(mask);
        end else begin
            count = $urandom_range(1, 8);
            repeat (count) push_columns(COLS_W'($urandom_range(15)), 1'b0, BLANK);
        end
    endtask

    always @(posedge i_clk) begin
        t_panel seen;
        t_panel want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = {o_row_lines, o_lock_lamp, o_entered_number, o_pressed_keys};
            if (panel_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, seen);
                mismatches++;
            end else begin
                want = panel_expected.pop_front();
                if (seen.row_lines !== want.row_lines) begin
                    $display("%0t: row_lines expected %h got %h", $time,
                             want.row_lines, seen.row_lines);
                    mismatches++;
                end
                if (seen.lamp !== want.lamp) begin
                    $display("%0t: lock_lamp expected %b got %b", $time, want.lamp, seen.lamp);
                    mismatches++;
                end
                if (seen.number !== want.number) begin
                    $display("%0t: entered_number expected %0d got %0d", $time,
                             want.number, seen.number);
                    mismatches++;
                end
                if (seen.keys !== want.keys) begin
                    $display("%0t: pressed_keys expected %h got %h", $time,
                             want.keys, seen.keys);
                    mismatches++;
                end
            end
        end
        i_out_ready <= calm || ($urandom_range(99) >= 36);
    end

    initial begin
        longint unsigned code;
        int              budget;
        int              wait_cycles;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_LEN; k++) begin
            if (k == SETUP_ROW) configure(10'd1, 37'd1);
            push_columns(DIRECTED_STEPS[k].cols, DIRECTED_STEPS[k].fixed,
                         DIRECTED_STEPS[k].want);
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1:       code = 0;
                2:       code = DIGIT_CAP;
                3:       code = CODE_ALL;
                5:       code = $urandom_range(9999);
                default: code = random_code();
            endcase
            configure(PERIOD_W'(PHASE_PERIOD[ph]), code[CODE_W-1:0]);
            calm      = (ph == 0);
            budget    = items_sent + PHASE_ITEMS[ph];
            held_keys = '0;
            // the longest period only gets column noise; key presses would take too long
            if (PHASE_PERIOD[ph] == 1023) begin
                while (items_sent < budget)
                    push_columns(COLS_W'($urandom_range(15)), 1'b0, BLANK);
            end else begin
                while (items_sent < budget) keypad_action();
            end
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        for (wait_cycles = 0; panel_expected.size() != 0 && wait_cycles < 10000; wait_cycles++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (panel_expected.size() != 0) begin
            $display("%0t: expected %0d more results, got none", $time, panel_expected.size());
            mismatches += panel_expected.size();
        end
        if (mismatches == 0) begin
            $display("keypad_scan_code_lock_tb: done, clean");
        end else begin
            $display("keypad_scan_code_lock_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/kscl_pkg.sv
hw/rtl/keypad_scan_code_lock.sv
verif/keypad_scan_code_lock_tb.sv
